// ===== rtl/hvrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hvrc_pkg
// Shared types and constants of the video request classifier.
// ----------------------------------------------------------------------------
package hvrc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOTAL_LENGTH = 1'b1;
  localparam logic [15:0] SERVER_PORT_RST      = 16'd80;
  localparam logic [15:0] MIN_TOTAL_LENGTH_RST = 16'd80;

  // Protocol constants
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [3:0]  MIN_TCP_WORDS = 4'd5;
  localparam logic [23:0] EXT_HEAD      = 24'h2E6D70;  // ".mp"
  localparam logic [7:0]  EXT_TAIL      = 8'h34;       // "4"
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  // IP header byte offsets
  localparam logic [15:0] POS_IHL      = 16'd0;
  localparam logic [15:0] POS_TLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TLEN_LO  = 16'd3;
  localparam logic [15:0] POS_PROTOCOL = 16'd9;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_NOT_TCP    = 2'd0,
    VERDICT_OTHER_PORT = 2'd1,
    VERDICT_NO_MATCH   = 2'd2,
    VERDICT_MATCH      = 2'd3
  } verdict_t;

  // Packet status handed from the parser to the verdict stage
  typedef struct packed {
    logic        is_tcp;
    logic [15:0] total_length;
    logic [15:0] destination_port;
    logic        full_prefix;
    logic        extension_found;
  } pkt_status_t;

  // "GET " request prefix, one byte per payload index
  function automatic logic [7:0] get_prefix_byte(input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = 8'h47;
      2'd1:    res = 8'h45;
      2'd2:    res = 8'h54;
      default: res = 8'h20;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/hvrc_in_if.sv =====
// ----------------------------------------------------------------------------
// hvrc_in_if
// Packet byte request channel: valid/ready with one byte and a last mark.
// ----------------------------------------------------------------------------
interface hvrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

// ===== rtl/hvrc_out_if.sv =====
// ----------------------------------------------------------------------------
// hvrc_out_if
// Verdict request channel: valid/ready with match flag and verdict code.
// ----------------------------------------------------------------------------
interface hvrc_out_if;
  logic       valid;
  logic       ready;
  logic       is_match;
  logic [1:0] verdict_code;

  modport source (output valid, output is_match, output verdict_code, input ready);
  modport sink   (input valid, input is_match, input verdict_code, output ready);
endinterface

// ===== rtl/http_video_request_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// http_video_request_classifier_unit
// Classifies IPv4 packets, one byte per request, as GET requests for .mp4.
// ----------------------------------------------------------------------------
//  channel | dir | payload                    | transfer
//  in_chan | in  | packet_byte[8], last_byte  | valid & ready
//  out_chan| out | is_match, verdict_code[2]  | valid & ready, one per packet
//  cfg_*   | in  | cfg_index[1], cfg_wdata[16]| cfg_we
//
//  One byte per cycle unless a last byte waits on a full result register.
//  Path: input register -> header capture/payload scan -> result register.
//  A full result register stalls only last bytes; other bytes keep flowing.
//  Synchronous active-low reset clears config to 80/80 and packet state.
// ----------------------------------------------------------------------------
module http_video_request_classifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  hvrc_in_if.sink                        in_chan,
  hvrc_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [hvrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hvrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hvrc_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_fire;
  logic        slot_free;
  logic [15:0] server_port_r;
  logic [15:0] min_len_r;
  pkt_status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r <= SERVER_PORT_RST;
      min_len_r     <= MIN_TOTAL_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERVER_PORT:      server_port_r <= cfg_wdata;
        CFG_MIN_TOTAL_LENGTH: min_len_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register; a last byte waits for a free result slot
  assign s1_fire       = s1_valid_r && (!s1_last_r || slot_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.packet_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  hvrc_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .pkt_byte (s1_byte_r),
    .last     (s1_last_r),
    .status   (status)
  );

  hvrc_verdict u_verdict (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_fire && s1_last_r),
    .status           (status),
    .server_port      (server_port_r),
    .min_total_length (min_len_r),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .is_match         (out_chan.is_match),
    .verdict_code     (out_chan.verdict_code),
    .slot_free        (slot_free)
  );

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("stalled byte lost from input register");

  a_body_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_last_r |-> s1_fire)
    else $error("non-final byte stalled");

endmodule

// ===== rtl/hvrc_parse.sv =====
// ----------------------------------------------------------------------------
// hvrc_parse
// Per-packet header capture and payload scan; one byte per fire.
// ----------------------------------------------------------------------------
module hvrc_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          pkt_byte,
  input  logic                last,
  output hvrc_pkg::pkt_status_t status
);
  import hvrc_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  ihw_r, ihw_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [3:0]  thw_r, thw_nxt;
  logic        prefix_ok_r, prefix_ok_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic        ext_r, ext_nxt;
  logic        zero_r, zero_nxt;

  logic [5:0]  tcp_start;
  logic [3:0]  words;
  logic [6:0]  payload_start;
  logic [15:0] ps_ext;
  logic        in_payload;
  logic        in_prefix;
  logic [1:0]  prefix_idx;

  // Field offsets; the header length byte always precedes every use
  assign tcp_start     = {ihw_r, 2'b00};
  assign words         = (thw_r < MIN_TCP_WORDS) ? MIN_TCP_WORDS : thw_r;
  assign payload_start = 7'(tcp_start) + 7'({words, 2'b00});
  assign ps_ext        = 16'(payload_start);
  assign in_payload    = pos_r >= ps_ext;
  assign in_prefix     = in_payload && (pos_r < (ps_ext + 16'd4));
  assign prefix_idx    = pos_r[1:0] - payload_start[1:0];

  // Next state for the current byte
  always_comb begin
    ihw_nxt       = ihw_r;
    tlen_nxt      = tlen_r;
    proto_nxt     = proto_r;
    dport_nxt     = dport_r;
    thw_nxt       = thw_r;
    prefix_ok_nxt = prefix_ok_r;
    recent_nxt    = recent_r;
    ext_nxt       = ext_r;
    zero_nxt      = zero_r;

    if (pos_r == POS_IHL)      ihw_nxt        = pkt_byte[3:0];
    if (pos_r == POS_TLEN_HI)  tlen_nxt[15:8] = pkt_byte;
    if (pos_r == POS_TLEN_LO)  tlen_nxt[7:0]  = pkt_byte;
    if (pos_r == POS_PROTOCOL) proto_nxt      = pkt_byte;

    if (pos_r == 16'(tcp_start) + 16'd2)  dport_nxt[15:8] = pkt_byte;
    if (pos_r == 16'(tcp_start) + 16'd3)  dport_nxt[7:0]  = pkt_byte;
    if (pos_r == 16'(tcp_start) + 16'd12) thw_nxt         = pkt_byte[7:4];

    if (in_prefix && (pkt_byte != get_prefix_byte(prefix_idx))) prefix_ok_nxt = 1'b0;

    // Extension search stops at the first zero byte
    if (in_payload && !zero_r) begin
      if (pkt_byte == 8'h00) begin
        zero_nxt = 1'b1;
      end else begin
        if ((recent_r == EXT_HEAD) && (pkt_byte == EXT_TAIL)) ext_nxt = 1'b1;
        recent_nxt = {recent_r[15:0], pkt_byte};
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
  end

  // Status as seen after this byte
  always_comb begin
    status.is_tcp           = (proto_nxt == PROTO_TCP);
    status.total_length     = tlen_nxt;
    status.destination_port = dport_nxt;
    status.full_prefix      = prefix_ok_nxt && (pos_r >= (ps_ext + 16'd3));
    status.extension_found  = ext_nxt;
  end

  // Packet state; the last byte returns it to the idle values
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      pos_r       <= '0;
      ihw_r       <= '0;
      tlen_r      <= '0;
      proto_r     <= '0;
      dport_r     <= '0;
      thw_r       <= '0;
      prefix_ok_r <= 1'b1;
      recent_r    <= '0;
      ext_r       <= 1'b0;
      zero_r      <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      ihw_r       <= ihw_nxt;
      tlen_r      <= tlen_nxt;
      proto_r     <= proto_nxt;
      dport_r     <= dport_nxt;
      thw_r       <= thw_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      recent_r    <= recent_nxt;
      ext_r       <= ext_nxt;
      zero_r      <= zero_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> (pos_r == '0) && prefix_ok_r && !ext_r && !zero_r)
    else $error("packet state not cleared after last byte");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pos_r))
    else $error("byte position moved without a byte");

endmodule

// ===== rtl/hvrc_verdict.sv =====
// ----------------------------------------------------------------------------
// hvrc_verdict
// Verdict decode against the configuration and the result register.
// ----------------------------------------------------------------------------
module hvrc_verdict (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  hvrc_pkg::pkt_status_t status,
  input  logic [15:0]          server_port,
  input  logic [15:0]          min_total_length,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 is_match,
  output logic [1:0]           verdict_code,
  output logic                 slot_free
);
  import hvrc_pkg::*;

  logic     valid_r;
  verdict_t code_r, code_nxt;

  // Priority decode of the verdict
  always_comb begin
    if (!status.is_tcp || (status.total_length < min_total_length)) begin
      code_nxt = VERDICT_NOT_TCP;
    end else if (status.destination_port != server_port) begin
      code_nxt = VERDICT_OTHER_PORT;
    end else if (status.full_prefix && status.extension_found) begin
      code_nxt = VERDICT_MATCH;
    end else begin
      code_nxt = VERDICT_NO_MATCH;
    end
  end

  assign slot_free = !valid_r || out_ready;

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign verdict_code = code_r;
  assign is_match     = (code_r == VERDICT_MATCH);

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("verdict loaded while result register occupied");

  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded verdict not presented");

endmodule

// ===== bench/tb_http_video_request_classifier_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_video_request_classifier_unit
// Self-checking bench for the video request classifier. IPv4/TCP packets are
// built byte by byte, some well formed with GET/.mp4 payloads and some broken
// or pure noise, and fed through a valid/ready driver. A bit-accurate
// predictor tracks header capture and payload scan and queues the verdict;
// the monitor checks each verdict against it. The run covers several port
// and length settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_http_video_request_classifier_unit;
  import hvrc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [31:0] GET_TEXT = "GET ";
  localparam logic [31:0] EXT_TEXT = ".mp4";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic     is_match;
    verdict_t code;
  } verdict_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hvrc_in_if  in_chan();
  hvrc_out_if out_chan();

  http_video_request_classifier_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and expectation stores
  logic [7:0]   pkt_buf[$];
  byte_req_t    byte_requests[$];
  verdict_rec_t expected_verdicts[$];
  byte_req_t    drv_req;
  verdict_rec_t mon_exp;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int cycle_count;
  int sent_pkts;
  int sent_bytes;
  int checked_verdicts;
  int verdict_hits[4];

  // Predictor: configuration copy and per-packet state
  logic [15:0] cfg_port;
  logic [15:0] cfg_min_len;
  logic [15:0] pkt_pos;
  logic [3:0]  hdr_words;
  logic [15:0] tot_len;
  logic [7:0]  proto;
  logic [15:0] dst_port;
  logic [3:0]  tcp_words;
  logic        prefix_good;
  logic [23:0] tail3;
  logic        ext_seen;
  logic        nul_seen;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still pending",
               cycle_count, expected_verdicts.size());
      $display("tb_http_video_request_classifier_unit failed");
      $finish;
    end
  end

  task automatic clear_packet_state();
    pkt_pos     = '0;
    hdr_words   = '0;
    tot_len     = '0;
    proto       = '0;
    dst_port    = '0;
    tcp_words   = '0;
    prefix_good = 1'b1;
    tail3       = '0;
    ext_seen    = 1'b0;
    nul_seen    = 1'b0;
  endtask

  // Predict the effect of one accepted byte; queue a verdict on the last one
  task automatic classify_byte(input logic [7:0] b, input logic last);
    int pos;
    int tcp_start;
    int words;
    int pay_start;
    int idx;
    logic full_prefix;
    verdict_rec_t v;
    pos = pkt_pos;
    // IP header fields
    if (pos == 0) hdr_words = b[3:0];
    if (pos == 2) tot_len[15:8] = b;
    if (pos == 3) tot_len[7:0] = b;
    if (pos == 9) proto = b;
    // TCP header fields, relative to the IP header length
    tcp_start = 4 * int'(hdr_words);
    if (pos == tcp_start + 2) dst_port[15:8] = b;
    if (pos == tcp_start + 3) dst_port[7:0] = b;
    if (pos == tcp_start + 12) tcp_words = b[7:4];
    words = (tcp_words < 5) ? 5 : int'(tcp_words);
    pay_start = tcp_start + 4 * words;
    // payload: prefix check and extension search up to the first NUL
    if (pos >= pay_start) begin
      idx = pos - pay_start;
      if (idx < 4 && b != GET_TEXT[31 - 8 * idx -: 8]) prefix_good = 1'b0;
      if (!nul_seen) begin
        if (b == 8'h00) begin
          nul_seen = 1'b1;
        end else begin
          if (tail3 == EXT_TEXT[31:8] && b == EXT_TEXT[7:0]) ext_seen = 1'b1;
          tail3 = {tail3[15:0], b};
        end
      end
    end
    if (pkt_pos != 16'hFFFF) pkt_pos = pkt_pos + 16'd1;
    if (last) begin
      full_prefix = prefix_good && (pos >= pay_start + 3);
      if (proto != PROTO_TCP || tot_len < cfg_min_len) v.code = VERDICT_NOT_TCP;
      else if (dst_port != cfg_port) v.code = VERDICT_OTHER_PORT;
      else if (full_prefix && ext_seen) v.code = VERDICT_MATCH;
      else v.code = VERDICT_NO_MATCH;
      v.is_match = (v.code == VERDICT_MATCH);
      expected_verdicts.push_back(v);
      clear_packet_state();
    end
  endtask

  // Request driver: predicts on each accepted byte, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) classify_byte(in_chan.packet_byte, in_chan.last_byte);
      if (!in_chan.valid || in_chan.ready) begin
        if (byte_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = byte_requests.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.packet_byte <= drv_req.data;
          in_chan.last_byte   <= drv_req.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR unexpected verdict: match=%0b code=%0d",
                     out_chan.is_match, out_chan.verdict_code);
        end else begin
          mon_exp = expected_verdicts.pop_front();
          checked_verdicts++;
          verdict_hits[mon_exp.code]++;
          if (out_chan.is_match !== mon_exp.is_match ||
              out_chan.verdict_code !== mon_exp.code) begin
            err_count++;
            if (err_count <= 10)
              $display("ERROR verdict %0d: expected match=%0b code=%0d, got match=%0b code=%0d",
                       checked_verdicts, mon_exp.is_match, mon_exp.code,
                       out_chan.is_match, out_chan.verdict_code);
          end
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Configuration write; the predictor copy follows at the write edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SERVER_PORT) cfg_port = data;
    else cfg_min_len = data;
  endtask

  // Wait until all requests are taken and every verdict has come back
  task automatic wait_idle();
    while (byte_requests.size() != 0 || in_chan.valid) @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Packet building
  task automatic build_header(input logic [3:0] ihl, input logic [15:0] tlen,
                              input logic [7:0] prot, input logic [15:0] port,
                              input logic [3:0] doff);
    int tcp0;
    int hlen;
    tcp0 = 4 * int'(ihl);
    hlen = tcp0 + 4 * ((doff < 5) ? 5 : int'(doff));
    pkt_buf.delete();
    repeat (hlen) pkt_buf.push_back(8'($urandom));
    pkt_buf[0] = {4'($urandom), ihl};
    pkt_buf[2] = tlen[15:8];
    pkt_buf[3] = tlen[7:0];
    pkt_buf[9] = prot;
    pkt_buf[tcp0 + 2] = port[15:8];
    pkt_buf[tcp0 + 3] = port[7:0];
    pkt_buf[tcp0 + 12] = {doff, 4'($urandom)};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_buf.push_back(s[i]);
  endtask

  // plain: lowercase path text; otherwise a mix rich in prefix/extension chars
  task automatic add_soup(input int n, input bit plain);
    logic [7:0] c;
    repeat (n) begin
      if (plain) begin
        c = ($urandom_range(9) == 0) ? 8'h2F : 8'($urandom_range(8'h7A, 8'h61));
      end else begin
        case ($urandom_range(11))
          0: c = "G";
          1: c = "E";
          2: c = "T";
          3: c = " ";
          4: c = ".";
          5: c = "m";
          6: c = "p";
          7: c = "4";
          8: c = 8'h00;
          default: c = 8'($urandom);
        endcase
      end
      pkt_buf.push_back(c);
    end
  endtask

  task automatic queue_packet();
    for (int i = 0; i < pkt_buf.size(); i++)
      byte_requests.push_back('{data: pkt_buf[i], last: (i == pkt_buf.size() - 1)});
    sent_pkts++;
    sent_bytes += pkt_buf.size();
  endtask

  task automatic add_random_packet();
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  prot;
    logic [15:0] port;
    logic [15:0] tlen;
    int r;
    int cut;
    // pure noise
    if ($urandom_range(99) < 8) begin
      pkt_buf.delete();
      repeat ($urandom_range(60, 1)) pkt_buf.push_back(8'($urandom));
      queue_packet();
      return;
    end
    ihl  = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom);
    doff = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom);
    prot = ($urandom_range(99) < 88) ? PROTO_TCP : 8'($urandom);
    r = $urandom_range(99);
    if (r < 75) port = cfg_port;
    else if (r < 85) port = cfg_port ^ (16'd1 << $urandom_range(15));
    else port = 16'($urandom);
    r = $urandom_range(99);
    if (r < 70) tlen = 16'($urandom_range(65535, cfg_min_len));
    else if (r < 80) tlen = cfg_min_len;
    else if (r < 90) tlen = cfg_min_len - 16'd1;
    else tlen = 16'($urandom);
    build_header(ihl, tlen, prot, port, doff);
    case ($urandom_range(5))
      0: begin
        add_text("GET ");
        add_soup($urandom_range(12), 1'b1);
        add_text(".mp4");
        add_soup($urandom_range(6), 1'b1);
      end
      1: add_soup($urandom_range(20), 1'b0);
      2: begin
        add_text("GET ");
        add_soup($urandom_range(6), 1'b1);
        pkt_buf.push_back(8'h00);
        add_text(".mp4");
      end
      3: begin
        add_text("GET .mp4");
        pkt_buf.push_back(8'h00);
        add_soup($urandom_range(8), 1'b0);
      end
      4: begin
        cut = $urandom_range(3);
        for (int i = 0; i < cut; i++) pkt_buf.push_back(GET_TEXT[31 - 8 * i -: 8]);
      end
      default: begin
        add_text("GET ");
        add_soup($urandom_range(16), 1'b0);
      end
    endcase
    // occasionally cut the packet short anywhere
    if ($urandom_range(99) < 5) begin
      cut = $urandom_range(pkt_buf.size(), 1);
      while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
    end
    queue_packet();
  endtask

  task automatic run_random(input int min_bytes, input int min_pkts);
    int b0;
    int p0;
    b0 = sent_bytes;
    p0 = sent_pkts;
    while (sent_bytes - b0 < min_bytes || sent_pkts - p0 < min_pkts) add_random_packet();
  endtask

  // Main sequence
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.packet_byte = '0;
    in_chan.last_byte   = 1'b0;
    out_chan.ready      = 1'b0;
    err_count           = 0;
    cycle_count         = 0;
    sent_pkts           = 0;
    sent_bytes          = 0;
    checked_verdicts    = 0;
    verdict_hits        = '{0, 0, 0, 0};
    cfg_port            = 16'd80;
    cfg_min_len         = 16'd80;
    clear_packet_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: reset settings, directed packets, slow sender and slower receiver
    send_idle_pct = 38;
    recv_idle_pct = 75;
    // plain match
    build_header(4'd5, 16'd80, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET /a.mp4");
    queue_packet();
    // not TCP
    build_header(4'd5, 16'd200, 8'd17, 16'd80, 4'd5);
    add_text("GET .mp4");
    queue_packet();
    // total length one below the minimum
    build_header(4'd5, 16'd79, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET .mp4");
    queue_packet();
    // other port
    build_header(4'd5, 16'd80, PROTO_TCP, 16'd81, 4'd5);
    add_text("GET .mp4");
    queue_packet();
    // wrong method
    build_header(4'd5, 16'hFFFF, PROTO_TCP, 16'd80, 4'd5);
    add_text("POST .mp4");
    queue_packet();
    // NUL before the extension
    build_header(4'd5, 16'd100, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET ");
    pkt_buf.push_back(8'h00);
    add_text(".mp4");
    queue_packet();
    // short payload, three prefix bytes only
    build_header(4'd5, 16'd100, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET");
    queue_packet();
    // full prefix but nothing else
    build_header(4'd5, 16'd100, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET ");
    queue_packet();
    // single-byte packet
    pkt_buf.delete();
    pkt_buf.push_back(8'hFF);
    queue_packet();
    // header length zero: TCP fields overlap the IP header
    build_header(4'd0, 16'd80, PROTO_TCP, 16'd80, 4'd5);
    add_text("GET x.mp4");
    queue_packet();
    // data offset zero is taken as five; maximum header lengths
    build_header(4'd5, 16'd90, PROTO_TCP, 16'd80, 4'd0);
    add_text("GET .mp4");
    queue_packet();
    build_header(4'd15, 16'd90, PROTO_TCP, 16'd80, 4'd15);
    add_text("GET /v.mp4?");
    queue_packet();
    run_random(380, 4);
    wait_idle();

    // Phase 2: all-zero settings, roles of the two stall rates swapped
    write_reg(CFG_SERVER_PORT, 16'h0000);
    write_reg(CFG_MIN_TOTAL_LENGTH, 16'h0000);
    send_idle_pct = 75;
    recv_idle_pct = 38;
    run_random(270, 3);
    wait_idle();

    // Phase 3: all-ones settings, no stalls
    write_reg(CFG_SERVER_PORT, 16'hFFFF);
    write_reg(CFG_MIN_TOTAL_LENGTH, 16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(270, 3);
    wait_idle();

    // Phase 4: random settings with a mid-phase drain
    write_reg(CFG_SERVER_PORT, 16'($urandom));
    write_reg(CFG_MIN_TOTAL_LENGTH, 16'($urandom_range(120, 20)));
    run_random(160, 2);
    wait_idle();
    run_random(160, 2);
    wait_idle();

    $display("covered %0d packets (%0d bytes) over four port/length settings; %0d verdicts checked",
             sent_pkts, sent_bytes, checked_verdicts);
    $display("verdicts seen: not tcp/short %0d, other port %0d, no match %0d, match %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
    if (err_count == 0) begin
      $display("tb_http_video_request_classifier_unit passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_http_video_request_classifier_unit failed");
    end
    $finish;
  end

endmodule
